FILE: hdl/rkf_pkg.sv
`timescale 1ns / 1ps
package rkf_pkg;

	localparam int PIX_W = 8;
	localparam int SUM_W = 13;
	localparam int CFG_W = 11;
	localparam int CFG_IDX_W = 3;
	localparam int OUT_POS_W = 10;
	localparam logic [PIX_W-1:0] PIX_MAX = {PIX_W{1'b1}};
	localparam int BOX_RECIP = 3641;
	localparam int BOX_SHIFT = 15;
	localparam int GAUSS_SHIFT = 4;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SEL_TOP = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SEL_LEFT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SEL_HEIGHT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SEL_WIDTH = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MODE = 3'd6;

	localparam int DEF_MAX_WIDTH = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;

	typedef enum logic [1:0] {
		KM_EDGE = 2'd0,
		KM_SHARPEN = 2'd1,
		KM_BOX = 2'd2,
		KM_GAUSS = 2'd3
	} kernel_mode_t;

	typedef logic [3*PIX_W-1:0] rgb_t;

	localparam logic signed [4:0] KERN [4][9] = '{
		'{-5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd8, -5'sd1, -5'sd1, -5'sd1, -5'sd1},
		'{5'sd0, -5'sd1, 5'sd0, -5'sd1, 5'sd5, -5'sd1, 5'sd0, -5'sd1, 5'sd0},
		'{5'sd1, 5'sd1, 5'sd1, 5'sd1, 5'sd1, 5'sd1, 5'sd1, 5'sd1, 5'sd1},
		'{5'sd1, 5'sd2, 5'sd1, 5'sd2, 5'sd4, 5'sd2, 5'sd1, 5'sd2, 5'sd1}
	};

	typedef struct packed {
		logic [PIX_W-1:0] in_red;
		logic [PIX_W-1:0] in_green;
		logic [PIX_W-1:0] in_blue;
		logic frame_start;
	} in_pix_t;

	typedef struct packed {
		logic [PIX_W-1:0] out_red;
		logic [PIX_W-1:0] out_green;
		logic [PIX_W-1:0] out_blue;
		logic [OUT_POS_W-1:0] out_row;
		logic [OUT_POS_W-1:0] out_col;
		logic run_last;
	} out_pix_t;

endpackage

FILE: hdl/rkf_line_buf.sv
`timescale 1ns / 1ps
module rkf_line_buf
	import rkf_pkg::*;
#(
	parameter int DEPTH = DEF_MAX_WIDTH,
	parameter int AW = $clog2(DEPTH)
) (
	input logic clk,
	input logic rd_en,
	input logic [AW-1:0] rd_addr,
	input logic wr_en,
	input logic [AW-1:0] wr_addr,
	input rgb_t wr_upper,
	input rgb_t wr_middle,
	output rgb_t rd_upper,
	output rgb_t rd_middle
);

	rgb_t upper_mem [DEPTH];
	rgb_t middle_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			upper_mem[wr_addr] <= wr_upper;
			middle_mem[wr_addr] <= wr_middle;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_upper <= upper_mem[rd_addr];
			rd_middle <= middle_mem[rd_addr];
		end
	end

endmodule

FILE: hdl/rkf_lane.sv
`timescale 1ns / 1ps
module rkf_lane
	import rkf_pkg::*;
(
	input logic clk,
	input logic en,
	input kernel_mode_t mode,
	input logic [8:0][PIX_W-1:0] win,
	output logic [PIX_W-1:0] result
);

	logic signed [SUM_W-1:0] sum;
	logic signed [SUM_W-1:0] sum_s3;
	logic [SUM_W-2:0] usum;
	logic [2*SUM_W-3:0] prod;

	always_comb begin
		sum = '0;
		for (int i = 0; i < 9; i++) begin
			sum = sum + $signed({{(SUM_W-PIX_W){1'b0}}, win[i]}) * SUM_W'(KERN[mode][i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3 <= sum;
		end
	end

	assign usum = sum_s3[SUM_W-2:0];
	assign prod = (2*SUM_W-2)'(usum) * (2*SUM_W-2)'(BOX_RECIP);

	always_comb begin
		case (mode)
			KM_BOX: result = PIX_W'(prod >> BOX_SHIFT);
			KM_GAUSS: result = PIX_W'(usum >> GAUSS_SHIFT);
			default: begin
				if (sum_s3 < 0) begin
					result = '0;
				end else if (sum_s3 > $signed({{(SUM_W-PIX_W){1'b0}}, PIX_MAX})) begin
					result = PIX_MAX;
				end else begin
					result = PIX_W'(sum_s3);
				end
			end
		endcase
	end

endmodule

FILE: hdl/rgb_3x3_kernel_filter_top.sv
`timescale 1ns / 1ps
// Streaming 3x3 kernel filter for RGB pixels in raster order.
// Input transactions carry one pixel on in_data; frame_start places it at row 0,
// column 0. Output transactions carry a filtered pixel with its row and column.
// A pixel transaction produces up to four output transactions: normally the
// pixel one row up and one column left, plus the remaining border pixels at the
// end of a row and of the last row. run_last marks the final one of each group.
// Configuration is written through cfg_we, cfg_index and cfg_data while idle.
// One pixel is accepted per cycle while in_stall is low; a pixel that produces
// several results holds the input while the output stage offers them, so a row
// end, each later pixel of the last row and the last pixel of a frame hold it.
// The first result of a pixel passes stages s1, s2 and s3 before the output stage offers it.
// When out_stall is high the pending result holds and the pipeline freezes;
// in_stall rises once the output stage cannot take the next group.
// Reset clears the position counters, the pipeline and the output stage and
// loads the default geometry; line store contents are undefined until written.
module rgb_3x3_kernel_filter_top
	import rkf_pkg::*;
#(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input in_pix_t in_data,
	output logic out_valid,
	input logic out_stall,
	output out_pix_t out_data,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_W-1:0] cfg_data
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int DW = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
	localparam int DH = ($clog2(MAX_HEIGHT + 1) > CFG_W) ? $clog2(MAX_HEIGHT + 1) : CFG_W;
	localparam int CMPW = ((DW > DH) ? DW : DH) + 2;

	logic [CFG_W-1:0] img_w_q, img_h_q, sel_h_q, sel_w_q;
	logic [CFG_W-2:0] sel_top_q, sel_left_q;
	kernel_mode_t mode_q;

	logic [RW-1:0] row_q;
	logic [CW-1:0] col_q;
	logic en;

	logic valid_s1, valid_s2, valid_s3;
	rgb_t px_s1;
	logic [RW-1:0] r_s1, r_s2, r_s3;
	logic [CW-1:0] c_s1, c_s2, c_s3;
	logic fwd_s1;
	rgb_t fup_q, fmid_q;
	rgb_t rd_up, rd_mid, up_eff, mid_eff;
	rgb_t win_q [3][3];

	logic [3:0] emit_s2, emit_s3;
	logic filt_s2, filt_s3;
	rgb_t center_s3, right_s3, below_s3, px_s3;

	logic [CMPW-1:0] w_sat, h_sat, rr, cc, orow, ocol, rin, cin;
	logic [RW-1:0] r_in, row_nx;
	logic [CW-1:0] c_in, col_nx;
	logic [3:0] emit_c;
	logic filt_c;

	logic [2:0][PIX_W-1:0] lane_res;
	out_pix_t cand [4];
	out_pix_t lst [4];
	out_pix_t res_q [4];
	logic [2:0] n_c, cnt_q;
	logic [1:0] idx_q;
	rgb_t center_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q <= CFG_W'(1024);
			img_h_q <= CFG_W'(1024);
			sel_top_q <= '0;
			sel_left_q <= '0;
			sel_h_q <= CFG_W'(1024);
			sel_w_q <= CFG_W'(1024);
			mode_q <= KM_EDGE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_WIDTH: img_w_q <= cfg_data;
				REG_IMAGE_HEIGHT: img_h_q <= cfg_data;
				REG_SEL_TOP: sel_top_q <= cfg_data[CFG_W-2:0];
				REG_SEL_LEFT: sel_left_q <= cfg_data[CFG_W-2:0];
				REG_SEL_HEIGHT: sel_h_q <= cfg_data;
				REG_SEL_WIDTH: sel_w_q <= cfg_data;
				REG_KERNEL_MODE: mode_q <= kernel_mode_t'(cfg_data[1:0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		if (CMPW'(img_w_q) < CMPW'(3)) begin
			w_sat = CMPW'(3);
		end else if (CMPW'(img_w_q) > CMPW'(MAX_WIDTH)) begin
			w_sat = CMPW'(MAX_WIDTH);
		end else begin
			w_sat = CMPW'(img_w_q);
		end
		if (CMPW'(img_h_q) < CMPW'(3)) begin
			h_sat = CMPW'(3);
		end else if (CMPW'(img_h_q) > CMPW'(MAX_HEIGHT)) begin
			h_sat = CMPW'(MAX_HEIGHT);
		end else begin
			h_sat = CMPW'(img_h_q);
		end
	end

	assign r_in = in_data.frame_start ? '0 : row_q;
	assign c_in = in_data.frame_start ? '0 : col_q;
	assign rin = CMPW'(r_in);
	assign cin = CMPW'(c_in);

	always_comb begin
		if (cin >= w_sat - CMPW'(1)) begin
			col_nx = '0;
			row_nx = (rin >= h_sat - CMPW'(1)) ? '0 : r_in + RW'(1);
		end else begin
			col_nx = c_in + CW'(1);
			row_nx = r_in;
		end
	end

	assign en = !(cnt_q != '0 && !(idx_q == 2'(cnt_q - 3'd1) && !out_stall));
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			fwd_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			fwd_s1 <= valid_s1 && (c_s1 == c_in);
			if (in_valid) begin
				row_q <= row_nx;
				col_q <= col_nx;
			end
		end
	end

	rkf_line_buf #(
		.DEPTH(MAX_WIDTH),
		.AW(CW)
	) u_line_buf (
		.clk(clk),
		.rd_en(en),
		.rd_addr(c_in),
		.wr_en(en && valid_s1),
		.wr_addr(c_s1),
		.wr_upper(mid_eff),
		.wr_middle(px_s1),
		.rd_upper(rd_up),
		.rd_middle(rd_mid)
	);

	assign up_eff = fwd_s1 ? fup_q : rd_up;
	assign mid_eff = fwd_s1 ? fmid_q : rd_mid;

	assign rr = CMPW'(r_s1);
	assign cc = CMPW'(c_s1);
	assign orow = rr - CMPW'(1);
	assign ocol = cc - CMPW'(1);

	always_comb begin
		emit_c[0] = (rr >= CMPW'(1)) && (cc >= CMPW'(1));
		emit_c[1] = (rr >= CMPW'(1)) && (cc == w_sat - CMPW'(1));
		emit_c[2] = (rr == h_sat - CMPW'(1)) && (cc >= CMPW'(1));
		emit_c[3] = (rr == h_sat - CMPW'(1)) && (cc == w_sat - CMPW'(1));
		filt_c = (orow >= CMPW'(1)) && (orow + CMPW'(2) <= h_sat) &&
			(ocol >= CMPW'(1)) && (ocol + CMPW'(2) <= w_sat) &&
			(orow >= CMPW'(sel_top_q)) && (orow < CMPW'(sel_top_q) + CMPW'(sel_h_q)) &&
			(ocol >= CMPW'(sel_left_q)) && (ocol < CMPW'(sel_left_q) + CMPW'(sel_w_q));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= {in_data.in_red, in_data.in_green, in_data.in_blue};
			r_s1 <= r_in;
			c_s1 <= c_in;
			fup_q <= mid_eff;
			fmid_q <= px_s1;
			r_s2 <= r_s1;
			c_s2 <= c_s1;
			emit_s2 <= valid_s1 ? emit_c : 4'b0000;
			filt_s2 <= filt_c;
			r_s3 <= r_s2;
			c_s3 <= c_s2;
			emit_s3 <= emit_s2;
			filt_s3 <= filt_s2;
			center_s3 <= win_q[1][1];
			right_s3 <= win_q[1][2];
			below_s3 <= win_q[2][1];
			px_s3 <= win_q[2][2];
			if (valid_s1) begin
				for (int k = 0; k < 3; k++) begin
					win_q[k][0] <= win_q[k][1];
					win_q[k][1] <= win_q[k][2];
				end
				win_q[0][2] <= up_eff;
				win_q[1][2] <= mid_eff;
				win_q[2][2] <= px_s1;
			end
		end
	end

	for (genvar ch = 0; ch < 3; ch++) begin : g_lane
		logic [8:0][PIX_W-1:0] lane_win;
		always_comb begin
			for (int i = 0; i < 9; i++) begin
				lane_win[i] = win_q[i / 3][i % 3][(2-ch)*PIX_W +: PIX_W];
			end
		end
		rkf_lane u_lane (
			.clk(clk),
			.en(en),
			.mode(mode_q),
			.win(lane_win),
			.result(lane_res[ch])
		);
	end

	assign center_out = filt_s3 ? {lane_res[0], lane_res[1], lane_res[2]} : center_s3;

	always_comb begin
		cand[0] = {center_out, OUT_POS_W'(r_s3 - RW'(1)), OUT_POS_W'(c_s3 - CW'(1)), 1'b0};
		cand[1] = {right_s3, OUT_POS_W'(r_s3 - RW'(1)), OUT_POS_W'(c_s3), 1'b0};
		cand[2] = {below_s3, OUT_POS_W'(r_s3), OUT_POS_W'(c_s3 - CW'(1)), 1'b0};
		cand[3] = {px_s3, OUT_POS_W'(r_s3), OUT_POS_W'(c_s3), 1'b0};
		for (int k = 0; k < 4; k++) begin
			cand[k].run_last = (emit_s3 >> (k + 1)) == 4'b0000;
			lst[k] = cand[k];
		end
		n_c = '0;
		for (int k = 0; k < 4; k++) begin
			if (emit_s3[k]) begin
				lst[n_c[1:0]] = cand[k];
				n_c = n_c + 3'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (en) begin
			cnt_q <= valid_s3 ? n_c : '0;
			idx_q <= '0;
		end else if (!out_stall) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				res_q[k] <= lst[k];
			end
		end
	end

	assign out_valid = cnt_q != '0;
	assign out_data = res_q[idx_q];

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import rkf_pkg::*;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_pix_t in_data;
	logic out_valid;
	logic out_stall;
	out_pix_t out_data;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	rgb_3x3_kernel_filter_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Shadow of the configuration and of the pixel pipeline.
	int unsigned m_width, m_height, m_top, m_left, m_sh, m_sw;
	kernel_mode_t m_mode;
	logic [PIX_W-1:0] row_up [1024][3];
	logic [PIX_W-1:0] row_mid [1024][3];
	logic [PIX_W-1:0] win [3][3][3];
	int unsigned pos_row, pos_col;

	in_pix_t pixel_q [$];
	out_pix_t expected_q [$];
	int errors;
	bit in_took, out_took;
	bit burst;
	bit hold_req, hold_done;
	int in_gap, out_gap, hold_left;

	function automatic int unsigned clip_dim(int unsigned v);
		if (v < 3)
			return 3;
		if (v > 1024)
			return 1024;
		return v;
	endfunction

	function automatic logic [PIX_W-1:0] kernel_pixel(int ch);
		int s;
		int coef [9];
		s = 0;
		case (m_mode)
			KM_EDGE: coef = '{-1, -1, -1, -1, 8, -1, -1, -1, -1};
			KM_SHARPEN: coef = '{0, -1, 0, -1, 5, -1, 0, -1, 0};
			KM_BOX: coef = '{1, 1, 1, 1, 1, 1, 1, 1, 1};
			default: coef = '{1, 2, 1, 2, 4, 2, 1, 2, 1};
		endcase
		for (int i = 0; i < 9; i++)
			s += int'(win[i / 3][i % 3][ch]) * coef[i];
		case (m_mode)
			KM_BOX: return PIX_W'(s / 9);
			KM_GAUSS: return PIX_W'(s >> 4);
			default: begin
				if (s < 0)
					return '0;
				if (s > 255)
					return PIX_MAX;
				return PIX_W'(s);
			end
		endcase
	endfunction

	function automatic out_pix_t make_pix(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
			logic [PIX_W-1:0] b, int unsigned row, int unsigned col);
		out_pix_t o;
		o.out_red = r;
		o.out_green = g;
		o.out_blue = b;
		o.out_row = OUT_POS_W'(row);
		o.out_col = OUT_POS_W'(col);
		o.run_last = 1'b0;
		return o;
	endfunction

	function automatic void filter_pixel(in_pix_t p);
		int unsigned w, h, r, c, ci, orow, ocol;
		logic [PIX_W-1:0] px [3];
		logic [PIX_W-1:0] v [3];
		bit interior, sel;
		out_pix_t grp [$];
		w = clip_dim(m_width);
		h = clip_dim(m_height);
		r = p.frame_start ? 0 : pos_row;
		c = p.frame_start ? 0 : pos_col;
		ci = (c < 1024) ? c : 1023;
		px[0] = p.in_red;
		px[1] = p.in_green;
		px[2] = p.in_blue;
		for (int k = 0; k < 3; k++)
			for (int ch = 0; ch < 3; ch++) begin
				win[k][0][ch] = win[k][1][ch];
				win[k][1][ch] = win[k][2][ch];
			end
		for (int ch = 0; ch < 3; ch++) begin
			win[0][2][ch] = row_up[ci][ch];
			win[1][2][ch] = row_mid[ci][ch];
			win[2][2][ch] = px[ch];
			row_up[ci][ch] = row_mid[ci][ch];
			row_mid[ci][ch] = px[ch];
		end
		if (r >= 1 && c >= 1) begin
			orow = r - 1;
			ocol = c - 1;
			interior = orow >= 1 && orow + 2 <= h && ocol >= 1 && ocol + 2 <= w;
			sel = orow >= m_top && orow < m_top + m_sh && ocol >= m_left &&
				ocol < m_left + m_sw;
			for (int ch = 0; ch < 3; ch++)
				v[ch] = (interior && sel) ? kernel_pixel(ch) : win[1][1][ch];
			grp.push_back(make_pix(v[0], v[1], v[2], orow, ocol));
		end
		if (r >= 1 && c == w - 1)
			grp.push_back(make_pix(win[1][2][0], win[1][2][1], win[1][2][2], r - 1, c));
		if (r == h - 1 && c >= 1)
			grp.push_back(make_pix(win[2][1][0], win[2][1][1], win[2][1][2], r, c - 1));
		if (r == h - 1 && c == w - 1)
			grp.push_back(make_pix(px[0], px[1], px[2], r, c));
		if (grp.size() > 0)
			grp[grp.size() - 1].run_last = 1'b1;
		foreach (grp[i])
			expected_q.push_back(grp[i]);
		if (c >= w - 1) begin
			pos_col = 0;
			pos_row = (r >= h - 1) ? 0 : r + 1;
		end else begin
			pos_col = c + 1;
			pos_row = r;
		end
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("tb_top: errors");
		$finish;
	end

	// Sampling at the rising edge.
	always @(posedge clk) begin
		in_took <= in_valid && !in_stall;
		out_took <= out_valid && !out_stall;
		if (in_valid && !in_stall)
			filter_pixel(in_data);
		if (out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				$error("unexpected output transaction row %0d col %0d",
					out_data.out_row, out_data.out_col);
				errors++;
			end else begin
				out_pix_t e;
				e = expected_q.pop_front();
				if (out_data.out_red !== e.out_red) begin
					$error("out_red expected %0d actual %0d", e.out_red, out_data.out_red);
					errors++;
				end
				if (out_data.out_green !== e.out_green) begin
					$error("out_green expected %0d actual %0d", e.out_green,
						out_data.out_green);
					errors++;
				end
				if (out_data.out_blue !== e.out_blue) begin
					$error("out_blue expected %0d actual %0d", e.out_blue, out_data.out_blue);
					errors++;
				end
				if (out_data.out_row !== e.out_row) begin
					$error("out_row expected %0d actual %0d", e.out_row, out_data.out_row);
					errors++;
				end
				if (out_data.out_col !== e.out_col) begin
					$error("out_col expected %0d actual %0d", e.out_col, out_data.out_col);
					errors++;
				end
				if (out_data.run_last !== e.run_last) begin
					$error("run_last expected %0d actual %0d", e.run_last,
						out_data.run_last);
					errors++;
				end
			end
		end
	end

	// Pixel driver.
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_took) begin
				in_valid <= 1'b1;
			end else if (in_gap > 0) begin
				in_gap <= in_gap - 1;
				in_valid <= 1'b0;
			end else if (pixel_q.size() > 0) begin
				in_data <= pixel_q.pop_front();
				in_valid <= 1'b1;
				in_gap <= burst ? 0 : $urandom_range(0, 13);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Output receiver.
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_took)
				out_gap = burst ? 0 : $urandom_range(0, 13);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left = hold_left - 1;
				out_stall <= 1'b1;
			end else if (out_gap > 0) begin
				out_gap = out_gap - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_W'(val);
		case (idx)
			REG_IMAGE_WIDTH: m_width = val & 11'h7ff;
			REG_IMAGE_HEIGHT: m_height = val & 11'h7ff;
			REG_SEL_TOP: m_top = val & 10'h3ff;
			REG_SEL_LEFT: m_left = val & 10'h3ff;
			REG_SEL_HEIGHT: m_sh = val & 11'h7ff;
			REG_SEL_WIDTH: m_sw = val & 11'h7ff;
			default: m_mode = kernel_mode_t'(val & 3);
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_geometry(int unsigned w, int unsigned h, int unsigned t,
			int unsigned l, int unsigned sh, int unsigned sw, int unsigned mode);
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
		write_reg(REG_SEL_TOP, t);
		write_reg(REG_SEL_LEFT, l);
		write_reg(REG_SEL_HEIGHT, sh);
		write_reg(REG_SEL_WIDTH, sw);
		write_reg(REG_KERNEL_MODE, mode);
	endtask

	task automatic wait_idle();
		wait (pixel_q.size() == 0 && !in_valid);
		wait (expected_q.size() == 0);
		repeat (10) @(negedge clk);
	endtask

	// style 0 random, 1 extremes, 2 bright center, 3 dark center
	task automatic push_frame(int unsigned n, int style, bit noise);
		in_pix_t p;
		for (int unsigned i = 0; i < n; i++) begin
			case (style)
				1: p = {{8{$urandom_range(0, 1) != 0}}, {8{$urandom_range(0, 1) != 0}},
					{8{$urandom_range(0, 1) != 0}}, 1'b0};
				2: p = (i == 4) ? {24'hffffff, 1'b0} : {24'h000000, 1'b0};
				3: p = (i == 4) ? {24'h000000, 1'b0} : {24'hffffff, 1'b0};
				default: p = {8'($urandom), 8'($urandom), 8'($urandom), 1'b0};
			endcase
			p.frame_start = (i == 0) || (noise && $urandom_range(0, 31) == 0);
			pixel_q.push_back(p);
		end
	endtask

	initial begin
		int unsigned w, h;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		errors = 0;
		burst = 1'b0;
		hold_req = 1'b0;
		hold_done = 1'b0;
		in_gap = 0;
		out_gap = 0;
		hold_left = 0;
		m_width = 1024;
		m_height = 1024;
		m_top = 0;
		m_left = 0;
		m_sh = 1024;
		m_sw = 1024;
		m_mode = KM_EDGE;
		pos_row = 0;
		pos_col = 0;
		for (int i = 0; i < 1024; i++)
			for (int ch = 0; ch < 3; ch++) begin
				row_up[i][ch] = '0;
				row_mid[i][ch] = '0;
			end
		for (int i = 0; i < 27; i++)
			win[i / 9][(i / 3) % 3][i % 3] = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Clamps at both ends, then the box blur, on the smallest image; the Gaussian run has an empty selection.
		set_geometry(0, 2, 0, 0, 1024, 1024, KM_EDGE);
		push_frame(9, 2, 0);
		wait_idle();
		write_reg(REG_KERNEL_MODE, KM_SHARPEN);
		push_frame(9, 3, 0);
		wait_idle();
		write_reg(REG_KERNEL_MODE, KM_BOX);
		push_frame(9, 1, 0);
		wait_idle();
		set_geometry(3, 3, 1, 1, 0, 1, KM_GAUSS);
		push_frame(9, 1, 0);
		wait_idle();

		// The receiver holds off long enough for the input to back up.
		set_geometry(6, 4, 0, 0, 1024, 1024, KM_GAUSS);
		burst = 1'b1;
		hold_req = 1'b1;
		push_frame(24, 0, 0);
		wait_idle();
		burst = 1'b0;

		// Oversized width saturates; a short run along the first row.
		set_geometry(2047, 3, 1023, 1023, 1024, 1024, KM_EDGE);
		burst = 1'b1;
		push_frame(8, 0, 0);
		wait_idle();
		burst = 1'b0;

		// Oversized height saturates; a new frame restarts part way down.
		set_geometry(3, 2047, 0, 0, 1, 1, KM_SHARPEN);
		push_frame(15, 0, 0);
		push_frame(9, 1, 0);
		wait_idle();

		for (int ph = 0; ph < 3; ph++) begin
			w = $urandom_range(3, 5);
			h = $urandom_range(3, 4);
			set_geometry(w, h, $urandom_range(0, 3), $urandom_range(0, 3),
				($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 6),
				($urandom_range(0, 5) == 0) ? 1024 : $urandom_range(1, 8),
				$urandom_range(0, 3));
			burst = ($urandom_range(0, 3) == 0);
			push_frame(w * h, $urandom_range(0, 3) == 0 ? 1 : 0, ph % 3 == 2);
			wait_idle();
		end

		if (errors == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule
